// ===== hw/rtl/mvt_pkg.sv =====
`default_nettype none
package mvt_pkg;

  // Fixed-point formats of the datapath.
  localparam int VALUE_BITS = 48;
  localparam int FRAC_BITS  = 16;
  localparam int EPS_BITS   = 16;
  localparam int EPS_FRAC   = 16;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd66;

  // Product |x| * eps and the forward linear term.
  localparam int PROD_W = VALUE_BITS + EPS_BITS;
  localparam int LIN_W  = PROD_W + 1 - EPS_FRAC;

  // Inverse radicand before the final shift by FRAC_BITS.
  localparam int RAW_A  = PROD_W + 18;
  localparam int RAW_B  = FRAC_BITS + 35;
  localparam int RAW_W  = ((RAW_A > RAW_B) ? RAW_A : RAW_B) + 1;
  localparam int RAD_U  = RAW_W + FRAC_BITS;
  localparam int RAD_W  = RAD_U + (RAD_U % 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // Forward magnitude before the final saturation.
  localparam int FWD_W  = ((ROOT_W + 1 > LIN_W) ? ROOT_W + 1 : LIN_W) + 1;

  // Division by 2*eps.
  localparam int NUM_W  = ROOT_W + 2;
  localparam int DIV_W  = EPS_BITS + 1;

  // Squaring of the quotient in two halves.
  localparam int T_W    = ROOT_W;
  localparam int H_W    = (T_W + 1) / 2;
  localparam int TH_W   = T_W - H_W;
  localparam int SQ_W   = 2 * T_W;
  localparam int M_W    = ((SQ_W + 1 > FWD_W) ? SQ_W + 1 : FWD_W);

  // Side data carried along the two cell chains.
  localparam int SQ_SIDE_W = 2 + LIN_W;
  localparam int DV_SIDE_W = 2 + FWD_W;

  typedef struct packed {
    logic                          mode;
    logic signed [VALUE_BITS-1:0]  value_in;
  } mvt_in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  value_out;
    logic                          saturated;
  } mvt_out_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mvt_sqrt_cell.sv =====
`default_nettype none
module mvt_sqrt_cell (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [mvt_pkg::REM_W-1:0]      rem_in,
  input  wire logic [mvt_pkg::ROOT_W-1:0]     root_in,
  input  wire logic [mvt_pkg::RAD_W-1:0]      rad_in,
  input  wire logic [mvt_pkg::SQ_SIDE_W-1:0]  side_in,
  output logic                                out_valid,
  output logic [mvt_pkg::REM_W-1:0]           rem_out,
  output logic [mvt_pkg::ROOT_W-1:0]          root_out,
  output logic [mvt_pkg::RAD_W-1:0]           rad_out,
  output logic [mvt_pkg::SQ_SIDE_W-1:0]       side_out
);
  import mvt_pkg::*;

  logic                 valid_r;
  logic [REM_W-1:0]     rem_r, rem_nxt, rem_sh, trial;
  logic [ROOT_W-1:0]    root_r, root_nxt;
  logic [RAD_W-1:0]     rad_r;
  logic [SQ_SIDE_W-1:0] side_r;
  logic                 ge;

  // One root bit: bring down two radicand bits and try root*4+1.
  always_comb begin
    rem_sh   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    trial    = {root_in, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_in[ROOT_W-2:0], ge};
  end

  // Valid is control state; the rest is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= {rad_in[RAD_W-3:0], 2'b00};
      side_r <= side_in;
    end
  end

  assign out_valid = valid_r;
  assign rem_out   = rem_r;
  assign root_out  = root_r;
  assign rad_out   = rad_r;
  assign side_out  = side_r;

endmodule
`default_nettype wire

// ===== hw/rtl/mvt_div_cell.sv =====
`default_nettype none
module mvt_div_cell (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [mvt_pkg::DIV_W-1:0]      divisor,
  input  wire logic [mvt_pkg::DIV_W-1:0]      rem_in,
  input  wire logic [mvt_pkg::NUM_W-1:0]      nq_in,
  input  wire logic [mvt_pkg::DV_SIDE_W-1:0]  side_in,
  output logic                                out_valid,
  output logic [mvt_pkg::DIV_W-1:0]           rem_out,
  output logic [mvt_pkg::NUM_W-1:0]           nq_out,
  output logic [mvt_pkg::DV_SIDE_W-1:0]       side_out
);
  import mvt_pkg::*;

  logic                 valid_r;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W:0]       rem_sh, diff;
  logic [NUM_W-1:0]     nq_r, nq_nxt;
  logic [DV_SIDE_W-1:0] side_r;
  logic                 ge;

  // One quotient bit: shift in the next numerator bit and subtract if it fits.
  // The numerator drains out of the top of nq while quotient bits enter below.
  always_comb begin
    rem_sh  = {rem_in, nq_in[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, divisor});
    diff    = rem_sh - {1'b0, divisor};
    rem_nxt = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    nq_nxt  = {nq_in[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      nq_r   <= nq_nxt;
      side_r <= side_in;
    end
  end

  assign out_valid = valid_r;
  assign rem_out   = rem_r;
  assign nq_out    = nq_r;
  assign side_out  = side_r;

endmodule
`default_nettype wire

// ===== hw/rtl/muzero_value_transform_core.sv =====
`default_nettype none
// Channel   Ports                         Beat
// input     in_valid/in_ready/in_data     mode and value_in, one value per beat
// result    out_valid/out_ready/out_data  value_out and saturated flag
// config    cfg_we/cfg_wdata              epsilon, one value per write
//
// One beat enters per cycle while the output is not blocked; each result passes
// 3 front stages, 50 square-root cells, 1 rounding stage, 52 divider cells and
// 3 stages for the square and saturation.
// Reset clears all valid bits and sets epsilon to its default.
// The whole pipeline holds while a result waits at the output unaccepted.
module muzero_value_transform_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire mvt_pkg::mvt_in_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output mvt_pkg::mvt_out_t                out_data,
  input  wire logic                        cfg_we,
  input  wire logic [mvt_pkg::EPS_BITS-1:0] cfg_wdata
);
  import mvt_pkg::*;

  localparam logic [ROOT_W:0]  ONE_R  = (ROOT_W+1)'(1) << FRAC_BITS;
  localparam logic [ROOT_W:0]  G_R    = (ROOT_W+1)'(1) << (FRAC_BITS + 16);
  localparam logic [M_W-1:0]   ONE_M  = M_W'(1) << FRAC_BITS;
  localparam logic [M_W-1:0]   HALF_M = M_W'(1) << (VALUE_BITS - 1);

  logic adv;

  // Epsilon register; zero acts as one.
  logic [EPS_BITS-1:0] eps_r, eps_eff;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end
  assign eps_eff = (eps_r == '0) ? EPS_BITS'(1) : eps_r;

  // Global advance: everything moves unless the output is blocked.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: sign and magnitude.
  logic                  s1_valid_r, s1_mode_r, s1_neg_r;
  logic [VALUE_BITS-1:0] s1_mag_r, s1_mag_nxt, v_raw;
  always_comb begin
    v_raw      = $unsigned(in_data.value_in);
    s1_mag_nxt = v_raw[VALUE_BITS-1] ? (~v_raw + 1'b1) : v_raw;
  end

  // Stage 2: |x|*eps and eps^2.
  logic                  s2_valid_r, s2_mode_r, s2_neg_r;
  logic [VALUE_BITS-1:0] s2_mag_r;
  logic [PROD_W-1:0]     s2_prod_r;
  logic [2*EPS_BITS-1:0] s2_esq_r;

  // Stage 3: radicand for the selected mode and forward linear term.
  logic                  s3_valid_r, s3_mode_r, s3_neg_r;
  logic [RAD_W-1:0]      s3_rad_r, s3_rad_nxt;
  logic [LIN_W-1:0]      s3_lin_r, s3_lin_nxt;
  logic [RAW_W-1:0]      inv_base;
  logic [PROD_W:0]       lin_sum;
  always_comb begin
    inv_base = (RAW_W'(s2_prod_r) << 18)
             + (RAW_W'(1) << (FRAC_BITS + 32))
             + (RAW_W'(eps_eff) << (FRAC_BITS + 18))
             + (RAW_W'(s2_esq_r) << (FRAC_BITS + 2));
    if (s2_mode_r) begin
      s3_rad_nxt = RAD_W'(inv_base) << FRAC_BITS;
    end else begin
      s3_rad_nxt = (RAD_W'(s2_mag_r) + (RAD_W'(1) << FRAC_BITS)) << FRAC_BITS;
    end
    lin_sum    = (PROD_W+1)'(s2_prod_r) + ((PROD_W+1)'(1) << (EPS_FRAC - 1));
    s3_lin_nxt = lin_sum[PROD_W:EPS_FRAC];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r <= in_data.mode;
      s1_neg_r  <= v_raw[VALUE_BITS-1];
      s1_mag_r  <= s1_mag_nxt;
      s2_mode_r <= s1_mode_r;
      s2_neg_r  <= s1_neg_r;
      s2_mag_r  <= s1_mag_r;
      s2_prod_r <= PROD_W'(s1_mag_r) * PROD_W'(eps_eff);
      s2_esq_r  <= eps_eff * eps_eff;
      s3_mode_r <= s2_mode_r;
      s3_neg_r  <= s2_neg_r;
      s3_rad_r  <= s3_rad_nxt;
      s3_lin_r  <= s3_lin_nxt;
    end
  end

  // Square-root chain, one root bit per cell.
  logic                 sq_valid [0:ROOT_W];
  logic [REM_W-1:0]     sq_rem   [0:ROOT_W];
  logic [ROOT_W-1:0]    sq_root  [0:ROOT_W];
  logic [RAD_W-1:0]     sq_rad   [0:ROOT_W];
  logic [SQ_SIDE_W-1:0] sq_side  [0:ROOT_W];

  assign sq_valid[0] = s3_valid_r;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_rad[0]   = s3_rad_r;
  assign sq_side[0]  = {s3_mode_r, s3_neg_r, s3_lin_r};

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    mvt_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (sq_valid[i]),
      .rem_in    (sq_rem[i]),
      .root_in   (sq_root[i]),
      .rad_in    (sq_rad[i]),
      .side_in   (sq_side[i]),
      .out_valid (sq_valid[i+1]),
      .rem_out   (sq_rem[i+1]),
      .root_out  (sq_root[i+1]),
      .rad_out   (sq_rad[i+1]),
      .side_out  (sq_side[i+1])
    );
  end

  // Rounding stage: round the root, finish the forward result, and form
  // the numerator d + eps for the inverse division.
  logic              rd_valid_r, rd_mode_r, rd_neg_r;
  logic [NUM_W-1:0]  rd_num_r, rd_num_nxt;
  logic [FWD_W-1:0]  rd_fwd_r, rd_fwd_nxt;
  logic [ROOT_W:0]   root_rnd, root_fl, d_val;
  logic [LIN_W-1:0]  sq_lin;
  always_comb begin
    sq_lin     = sq_side[ROOT_W][LIN_W-1:0];
    root_fl    = {1'b0, sq_root[ROOT_W]};
    root_rnd   = root_fl + (ROOT_W+1)'(sq_rem[ROOT_W] > REM_W'(root_fl));
    rd_fwd_nxt = FWD_W'((root_rnd >= ONE_R) ? (root_rnd - ONE_R) : '0)
               + FWD_W'(sq_lin);
    d_val      = (root_rnd >= G_R) ? (root_rnd - G_R) : '0;
    rd_num_nxt = NUM_W'(d_val) + NUM_W'(eps_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (adv) begin
      rd_valid_r <= sq_valid[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_mode_r <= sq_side[ROOT_W][SQ_SIDE_W-1];
      rd_neg_r  <= sq_side[ROOT_W][SQ_SIDE_W-2];
      rd_num_r  <= rd_num_nxt;
      rd_fwd_r  <= rd_fwd_nxt;
    end
  end

  // Divider chain by 2*eps, one quotient bit per cell.
  logic                 dv_valid [0:NUM_W];
  logic [DIV_W-1:0]     dv_rem   [0:NUM_W];
  logic [NUM_W-1:0]     dv_nq    [0:NUM_W];
  logic [DV_SIDE_W-1:0] dv_side  [0:NUM_W];
  logic [DIV_W-1:0]     divisor;

  assign divisor     = {eps_eff, 1'b0};
  assign dv_valid[0] = rd_valid_r;
  assign dv_rem[0]   = '0;
  assign dv_nq[0]    = rd_num_r;
  assign dv_side[0]  = {rd_mode_r, rd_neg_r, rd_fwd_r};

  for (genvar j = 0; j < NUM_W; j++) begin : g_div
    mvt_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (dv_valid[j]),
      .divisor   (divisor),
      .rem_in    (dv_rem[j]),
      .nq_in     (dv_nq[j]),
      .side_in   (dv_side[j]),
      .out_valid (dv_valid[j+1]),
      .rem_out   (dv_rem[j+1]),
      .nq_out    (dv_nq[j+1]),
      .side_out  (dv_side[j+1])
    );
  end

  // Partial products of t*t.
  logic                 p1_valid_r, p1_mode_r, p1_neg_r;
  logic [FWD_W-1:0]     p1_fwd_r;
  logic [2*TH_W-1:0]    p1_hh_r;
  logic [TH_W+H_W-1:0]  p1_hl_r;
  logic [2*H_W-1:0]     p1_ll_r;
  logic [T_W-1:0]       t_val;
  logic [TH_W-1:0]      t_hi;
  logic [H_W-1:0]       t_lo;
  assign t_val = dv_nq[NUM_W][T_W-1:0];
  assign t_hi  = t_val[T_W-1:H_W];
  assign t_lo  = t_val[H_W-1:0];

  // Sum of partial products, rounding, and mode select.
  logic                 p2_valid_r, p2_neg_r;
  logic [M_W-1:0]       p2_m_r, p2_m_nxt, sq_sum, tt;
  always_comb begin
    sq_sum = (M_W'(p1_hh_r) << (2 * H_W))
           + (M_W'(p1_hl_r) << (H_W + 1))
           + M_W'(p1_ll_r);
    tt     = (sq_sum + (M_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (p1_mode_r) begin
      p2_m_nxt = (tt >= ONE_M) ? (tt - ONE_M) : '0;
    end else begin
      p2_m_nxt = M_W'(p1_fwd_r);
    end
  end

  // Output register: saturate and apply the sign.
  logic                  out_valid_r;
  mvt_out_t              out_data_r, out_data_nxt;
  logic [M_W-1:0]        limit, mag_sat;
  logic                  sat;
  always_comb begin
    limit   = p2_neg_r ? HALF_M : (HALF_M - 1'b1);
    sat     = (p2_m_r > limit);
    mag_sat = sat ? limit : p2_m_r;
    out_data_nxt.value_out = p2_neg_r ? $signed(~mag_sat[VALUE_BITS-1:0] + 1'b1)
                                      : $signed(mag_sat[VALUE_BITS-1:0]);
    out_data_nxt.saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r  <= dv_valid[NUM_W];
      p2_valid_r  <= p1_valid_r;
      out_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_mode_r  <= dv_side[NUM_W][DV_SIDE_W-1];
      p1_neg_r   <= dv_side[NUM_W][DV_SIDE_W-2];
      p1_fwd_r   <= dv_side[NUM_W][FWD_W-1:0];
      p1_hh_r    <= (2*TH_W)'(t_hi) * (2*TH_W)'(t_hi);
      p1_hl_r    <= (TH_W+H_W)'(t_hi) * (TH_W+H_W)'(t_lo);
      p1_ll_r    <= (2*H_W)'(t_lo) * (2*H_W)'(t_lo);
      p2_neg_r   <= p1_neg_r;
      p2_m_r     <= p2_m_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/mvt_checker.sv =====
`default_nettype none
module mvt_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire mvt_pkg::mvt_out_t            out_data
);
  import mvt_pkg::*;

  localparam logic signed [VALUE_BITS-1:0] MAX_V = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] MIN_V = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // No result beat right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // A waiting result holds steady.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A blocked output stalls the input side.
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output blocked");

  // An empty output never stalls the input side.
  a_free_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A saturated result sits at one end of the range.
  a_sat_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.value_out == MAX_V) || (out_data.value_out == MIN_V))
    else $error("saturated beat not at range end");

endmodule

bind muzero_value_transform_core mvt_checker u_mvt_checker (.*);
`default_nettype wire
